/* design/bir_pkg.sv */
// shared types and constants for the bilinear image rotator
`default_nettype none
package bir_pkg;

	localparam int COORD_W    = 9;
	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CANVAS_MAX = 511;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL       = 3'd5;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [PIX_W-1:0]   in_ch0;
		logic [PIX_W-1:0]   in_ch1;
		logic [PIX_W-1:0]   in_ch2;
		logic [PIX_W-1:0]   in_ch3;
	} in_t;

	typedef struct packed {
		logic [PIX_W-1:0]   out_ch0;
		logic [PIX_W-1:0]   out_ch1;
		logic [PIX_W-1:0]   out_ch2;
		logic [PIX_W-1:0]   out_ch3;
		logic               inside_res;
		logic [COORD_W-1:0] canvas_width;
		logic [COORD_W-1:0] canvas_height;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMUL,
		ST_CSUM,
		ST_PMUL,
		ST_PROD,
		ST_PSUM,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_ACC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       cap;
		logic       st_wr;
		logic       cmul;
		logic       csum;
		logic       pmul;
		logic       psum;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wgt_en;
		logic       acc_clr;
		logic       acc_en;
		logic [1:0] acc_sel;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic in_src;
	} status_t;

endpackage
`default_nettype wire

/* design/bilinear_image_rotator.sv */
// top level of the bilinear image rotator
//
// Command-style block. An item is taken at a clock edge with start high and
// busy low. A load item (kind 0) writes one pixel word into the frame store
// in that same cycle if col < MAX_WIDTH and row < MAX_HEIGHT, and gives no
// result; the next item may follow at once. A read item (kind 1) names an
// output canvas pixel; busy rises for the work and the result appears on
// result with done high for exactly one cycle. The receiver cannot stall;
// result holds only until the next read ends. A read steps through CMUL,
// CSUM, PMUL, PROD, PSUM, the four single-port frame store reads RD0..RD3,
// ACC and FIN; outside the source it goes from RD0 to FIN. A new item is
// accepted during the done cycle. Configuration is written through
// cfg_we/cfg_index/cfg_wdata while idle; the user is bound to this, the
// block does not enforce it. Reset loads register defaults and sets the
// sequencer idle; the frame store has no reset, garbage until written.
`default_nettype none
module bilinear_image_rotator #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 14
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire bir_pkg::in_t                   item,
	output logic                                done,
	output bir_pkg::out_t                       result,
	input  wire logic                           cfg_we,
	input  wire logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bir_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bir_pkg::*;

	cmd_t    cmd;
	status_t status;

	bir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	bir_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.result    (result),
		.done      (done)
	);

endmodule
`default_nettype wire

/* design/bir_ctrl.sv */
// sequencer for loads and rotated-pixel reads
`default_nettype none
module bir_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            kind,
	input  wire bir_pkg::status_t status,
	output bir_pkg::cmd_t        cmd,
	output logic                 busy
);
	import bir_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (kind == KIND_LOAD) begin
						cmd.st_wr = 1'b1;
					end else begin
						cmd.cap = 1'b1;
						state_d = ST_CMUL;
					end
				end
			end
			ST_CMUL: begin
				cmd.cmul = 1'b1;
				state_d  = ST_CSUM;
			end
			ST_CSUM: begin
				cmd.csum = 1'b1;
				state_d  = ST_PMUL;
			end
			ST_PMUL: begin
				cmd.pmul = 1'b1;
				state_d  = ST_PROD;
			end
			// rotation products register here
			ST_PROD: begin
				state_d = ST_PSUM;
			end
			ST_PSUM: begin
				cmd.psum = 1'b1;
				state_d  = ST_RD0;
			end
			ST_RD0: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = 2'd0;
				cmd.wgt_en  = 1'b1;
				cmd.acc_clr = 1'b1;
				// outside the source: no texels needed
				state_d = status.in_src ? ST_RD1 : ST_FIN;
			end
			ST_RD1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = 2'd1;
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = 2'd0;
				state_d     = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = 2'd2;
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = 2'd1;
				state_d     = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = 2'd3;
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = 2'd2;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = 2'd3;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* design/bir_datapath.sv */
// frame store, config registers, mapping arithmetic and bilinear blend
`default_nettype none
module bir_datapath #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 14
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire bir_pkg::in_t                         item,
	input  wire logic                                 cfg_we,
	input  wire logic [bir_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [bir_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  wire bir_pkg::cmd_t                        cmd,
	output bir_pkg::status_t                          status,
	output bir_pkg::out_t                             result,
	output logic                                      done
);
	import bir_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int XA    = $clog2(MAX_WIDTH);
	localparam int YA    = $clog2(MAX_HEIGHT);
	localparam int DEPTH = 1 << (XA + YA);
	localparam int XB    = ((F + 10 > 27) ? F + 10 : 27) + 2;
	localparam int WB    = 2 * F + 4;
	localparam int AB    = 2 * F + 12;

	// configuration
	logic [8:0]         src_width_q, src_height_q;
	logic [2:0]         channels_q;
	logic signed [15:0] cos_q, sin_q;
	logic [7:0]         fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 9'd256;
			src_height_q <= 9'd256;
			channels_q   <= 3'd3;
			cos_q        <= 16'sd16384;
			sin_q        <= 16'sd0;
			fill_q       <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg_wdata[8:0];
				CFG_SRC_HEIGHT: src_height_q <= cfg_wdata[8:0];
				CFG_CHANNELS:   channels_q   <= cfg_wdata[2:0];
				CFG_COS:        cos_q        <= cfg_wdata;
				CFG_SIN:        sin_q        <= cfg_wdata;
				CFG_FILL:       fill_q       <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// saturated working values
	logic [8:0]  w, h;
	logic [2:0]  nch;
	logic [16:0] ac, as;

	always_comb begin
		if (src_width_q < 9'd2) w = 9'd2;
		else if (32'(src_width_q) > MAX_WIDTH) w = 9'(MAX_WIDTH);
		else w = src_width_q;
		if (src_height_q < 9'd2) h = 9'd2;
		else if (32'(src_height_q) > MAX_HEIGHT) h = 9'(MAX_HEIGHT);
		else h = src_height_q;
		if (channels_q == 3'd0) nch = 3'd1;
		else if (channels_q > 3'd4) nch = 3'd4;
		else nch = channels_q;
		ac = cos_q[15] ? 17'(-{cos_q[15], cos_q}) : 17'({1'b0, cos_q});
		as = sin_q[15] ? 17'(-{sin_q[15], sin_q}) : 17'({1'b0, sin_q});
	end

	// captured request
	logic [8:0] col_q, row_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			col_q <= item.col;
			row_q <= item.row;
		end
	end

	// canvas size
	logic [25:0] pwc_q, phs_q, pws_q, phc_q;
	logic [27:0] cw_round, ch_round, cw_full, ch_full;
	logic [8:0]  cw_q, ch_q;
	logic signed [11:0] dx_q, dy_q;

	always_comb begin
		cw_round = 28'(pwc_q) + 28'(phs_q) + 28'((1 << F) - 1);
		ch_round = 28'(pws_q) + 28'(phc_q) + 28'((1 << F) - 1);
		cw_full  = cw_round >> F;
		ch_full  = ch_round >> F;
	end

	always_ff @(posedge clk) begin
		if (cmd.cmul) begin
			pwc_q <= 26'(w * ac);
			phs_q <= 26'(h * as);
			pws_q <= 26'(w * as);
			phc_q <= 26'(h * ac);
		end
		if (cmd.csum) begin
			cw_q <= (cw_full > 28'(CANVAS_MAX)) ? 9'(CANVAS_MAX) : cw_full[8:0];
			ch_q <= (ch_full > 28'(CANVAS_MAX)) ? 9'(CANVAS_MAX) : ch_full[8:0];
		end
	end

	// offsets from the canvas centre, doubled
	always_ff @(posedge clk) begin
		if (cmd.pmul) begin
			dx_q <= 12'({2'b00, col_q, 1'b0}) - 12'({3'b000, cw_q});
			dy_q <= 12'({2'b00, row_q, 1'b0}) - 12'({3'b000, ch_q});
		end
	end

	// rotation products; the pmul step only sets the offsets, products follow
	logic signed [27:0] cx, sy, sx, cy;
	logic signed [27:0] cx_q, sy_q, sx_q, cy_q;

	always_comb begin
		cx = 28'(cos_q * dx_q);
		sy = 28'(sin_q * dy_q);
		sx = 28'(sin_q * dx_q);
		cy = 28'(cos_q * dy_q);
	end

	always_ff @(posedge clk) begin
		cx_q <= cx;
		sy_q <= sy;
		sx_q <= sx;
		cy_q <= cy;
	end

	// source position with F+1 fraction bits
	logic signed [XB-1:0] pos_x, pos_y, wsh, hsh, lim_x, lim_y;
	logic                 inside_d;

	always_comb begin
		wsh   = $signed(XB'(w) << F);
		hsh   = $signed(XB'(h) << F);
		lim_x = $signed(XB'(w - 9'd1) << (F + 1));
		lim_y = $signed(XB'(h - 9'd1) << (F + 1));
		pos_x = XB'(cx_q) + XB'(sy_q) + wsh;
		pos_y = XB'(cy_q) - XB'(sx_q) + hsh;
		inside_d = (col_q < cw_q) && (row_q < ch_q) &&
			!pos_x[XB-1] && (pos_x < lim_x) &&
			!pos_y[XB-1] && (pos_y < lim_y);
	end

	logic [8:0] x1_q, y1_q;
	logic [F:0] fx_q, fy_q;
	logic       inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (cmd.psum) begin
			inside_q <= inside_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.psum) begin
			x1_q <= pos_x[F+9:F+1];
			y1_q <= pos_y[F+9:F+1];
			fx_q <= pos_x[F:0];
			fy_q <= pos_y[F:0];
		end
	end

	assign status.in_src = inside_q;

	// blend weights
	logic [F+1:0] wx0, wy0, wx1, wy1;
	logic [WB-1:0] wgt_q [4];

	always_comb begin
		wx0 = {1'b1, {(F + 1){1'b0}}} - {1'b0, fx_q};
		wy0 = {1'b1, {(F + 1){1'b0}}} - {1'b0, fy_q};
		wx1 = {1'b0, fx_q};
		wy1 = {1'b0, fy_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.wgt_en) begin
			wgt_q[0] <= WB'(wx0 * wy0);
			wgt_q[1] <= WB'(wx1 * wy0);
			wgt_q[2] <= WB'(wx0 * wy1);
			wgt_q[3] <= WB'(wx1 * wy1);
		end
	end

	// frame store, single port
	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;
	logic [31:0] col_ext, row_ext, rx_ext, ry_ext;
	logic [8:0]  rx, ry;
	logic [XA+YA-1:0] addr;
	logic        load_ok;

	always_comb begin
		rx = cmd.rd_sel[0] ? x1_q + 9'd1 : x1_q;
		ry = cmd.rd_sel[1] ? y1_q + 9'd1 : y1_q;
		col_ext = 32'(item.col);
		row_ext = 32'(item.row);
		rx_ext  = 32'(rx);
		ry_ext  = 32'(ry);
		load_ok = (col_ext < MAX_WIDTH) && (row_ext < MAX_HEIGHT);
		if (cmd.st_wr) addr = {row_ext[YA-1:0], col_ext[XA-1:0]};
		else addr = {ry_ext[YA-1:0], rx_ext[XA-1:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.st_wr && load_ok) begin
			mem[addr] <= {item.in_ch3, item.in_ch2, item.in_ch1, item.in_ch0};
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	// per-channel accumulation, one texel per beat
	logic [AB-1:0] acc_q [4];
	logic [AB-1:0] prod [4];
	logic [AB-1:0] rnd [4];
	logic [AB-1:0] vfull [4];
	logic [7:0]    vch [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			prod[k]  = AB'(rdata_q[8*k +: 8] * wgt_q[cmd.acc_sel]);
			rnd[k]   = acc_q[k] + (AB'(1) << (2 * F + 1));
			vfull[k] = rnd[k] >> (2 * F + 2);
			if (!inside_q) vch[k] = fill_q;
			else if (vfull[k] > AB'(255)) vch[k] = 8'd255;
			else vch[k] = vfull[k][7:0];
			if (3'(k) >= nch) vch[k] = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (cmd.acc_clr) acc_q[k] <= '0;
			else if (cmd.acc_en) acc_q[k] <= acc_q[k] + prod[k];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			result.out_ch0       <= vch[0];
			result.out_ch1       <= vch[1];
			result.out_ch2       <= vch[2];
			result.out_ch3       <= vch[3];
			result.inside_res    <= inside_q;
			result.canvas_width  <= cw_q;
			result.canvas_height <= ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.fin;
		end
	end

endmodule
`default_nettype wire

/* design/bir_checker.sv */
// port-level checks for the bilinear image rotator, bound to the top level
`default_nettype none
module bir_sva (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire bir_pkg::in_t  item,
	input wire logic          done
);
	import bir_pkg::*;

	// a result beat only comes with the sequencer back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// a read passes through the mapping and read states before FIN, so result beats never touch
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back result beats");

	// a load finishes in its accepting cycle
	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind == KIND_LOAD) |=> (!busy && !done))
		else $error("load did not complete in one cycle");

	// a read keeps the block busy
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind == KIND_READ) |=> (busy && !done))
		else $error("read not taken up");

endmodule

bind bilinear_image_rotator bir_sva u_bir_sva (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done)
);
`default_nettype wire
